### rtl/core/klt_pkg.sv
// Shared types, constants and arithmetic helpers for the Kelly-Lochbaum tract step.
// Used by the controller, the datapath and the top level; depends on nothing.
package klt_pkg;

  localparam int WAVE_W = 24;
  localparam int COEF_W = 18;
  localparam int RAD_W  = 16;
  localparam int LOSS_W = 17;
  localparam int IDX_W  = 6;
  localparam int REQ_W  = 2;

  localparam logic [LOSS_W-1:0] LOSS_UNITY = 17'd65536;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RADIUS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Result kinds.
  localparam logic KIND_LIP      = 1'b0;
  localparam logic KIND_PRESSURE = 1'b1;

  // Controller states.
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH,
    ST_END_RD, ST_END_MUL, ST_END_RND,
    ST_J_MK, ST_J_LO, ST_J_HI, ST_J_WR, ST_LAST_WR,
    ST_PR_RD, ST_PR_OUT,
    ST_RAD_WR, ST_K_RD, ST_K_SQ, ST_K_SUM, ST_K_DIV, ST_K_WR
  } klt_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD,
    OP_END_RD, OP_END_MUL, OP_END_RND,
    OP_J_MK, OP_J_LO, OP_J_HI, OP_J_WR, OP_LAST_WR,
    OP_PR_RD, OP_PR_OUT,
    OP_RAD_WR, OP_K_RD, OP_K_SQ, OP_K_SUM, OP_K_DIV, OP_K_WR
  } klt_op_t;

  typedef struct packed {
    klt_op_t op;
  } klt_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             idx_ok;
    logic             idx_zero;
    logic             idx_last;
    logic             j_last;
    logic             clr_last;
    logic             div_last;
    logic             phase_hi;
  } klt_status_t;

  // Divide by 2^sh rounding to nearest with ties away from zero, then
  // saturate to the signed wave range.
  function automatic logic signed [WAVE_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                       input int sh);
    logic        neg;
    logic [63:0] mag;
    logic signed [WAVE_W-1:0] res;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (!neg && mag > 64'd8388607) begin
      res = 24'sh7FFFFF;
    end else if (neg && mag > 64'd8388608) begin
      res = 24'sh800000;
    end else if (neg) begin
      res = signed'(-mag[WAVE_W-1:0]);
    end else begin
      res = signed'(mag[WAVE_W-1:0]);
    end
    return res;
  endfunction

endpackage

### rtl/core/klt_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; every tract store is one instance of it.
module klt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/klt_datapath.sv
// Datapath of the tract step: wave, radius and coefficient memories, junction
// arithmetic, coefficient divider and result register. Uses klt_pkg and klt_ram.
module klt_datapath
  import klt_pkg::*;
#(
  parameter int SECTIONS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  klt_cmd_t                 cmd,
  output klt_status_t              status,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [IDX_W-1:0]         section_index,
  input  logic signed [WAVE_W-1:0] excitation,
  input  logic [RAD_W-1:0]         radius_value,
  input  logic                     cfg_we,
  input  logic [LOSS_W-1:0]        cfg_data,
  output logic                     result_strobe,
  output logic signed [WAVE_W-1:0] result_value,
  output logic                     result_kind
);

  localparam int AW = $clog2(SECTIONS);
  localparam int TF_W = 44;
  localparam logic [AW-1:0] LAST = AW'(SECTIONS - 1);

  // Latched request.
  logic [REQ_W-1:0]         req_q;
  logic [AW-1:0]            idx_q;
  logic                     idx_ok_q;
  logic signed [WAVE_W-1:0] exc_q;
  logic [RAD_W-1:0]         rad_q;

  logic [LOSS_W-1:0] loss;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     j;
  logic              phase_hi;

  // Memory ports.
  logic              fw_we, bw_we, rr_we, kr_we;
  logic              fw_re, bw_re, rr_re, kr_re;
  logic [AW-1:0]     fw_waddr, bw_waddr, rr_waddr, kr_waddr;
  logic [AW-1:0]     fw_raddr, bw_raddr, rr_raddr, kr_raddr;
  logic [WAVE_W-1:0] fw_wdata, bw_wdata;
  logic [RAD_W-1:0]  rr_wdata;
  logic [COEF_W-1:0] kr_wdata;
  logic [WAVE_W-1:0] f_rd, b_rd;
  logic [RAD_W-1:0]  r_rd;
  logic [COEF_W-1:0] k_rd;

  // Sample-step registers.
  logic signed [WAVE_W-1:0] lip_q, fpend, blast;
  logic signed [42:0]       p0_q, pl_q;
  logic signed [TF_W-1:0]   tf_q, tb_q;
  logic signed [63:0]       accf, accb;

  // Coefficient registers.
  logic [31:0]       sq_a, sq_b;
  logic [32:0]       s_q;
  logic              neg_q, zero_q;
  logic [34:0]       rem;
  logic [17:0]       quo;
  logic [4:0]        div_cnt;

  // Combinational arithmetic.
  logic signed [17:0]       loss_s;
  logic signed [WAVE_W:0]   jd;
  logic signed [42:0]       m_prod;
  logic signed [WAVE_W:0]   e0_sum, el_neg, pr_sum;
  logic signed [42:0]       e0_prod, el_prod;
  logic signed [22:0]       tfl, tbl;
  logic signed [21:0]       tfh, tbh;
  logic signed [40:0]       pf_lo, pb_lo;
  logic signed [39:0]       pf_hi, pb_hi;
  logic signed [WAVE_W-1:0] b_new, f_new;
  logic [31:0]              sq_rd, sq_nw;
  logic                     rem_ge;
  logic [34:0]              rem_sub;
  logic [18:0]              q_round;
  logic [COEF_W-1:0]        k_new;

  assign loss_s  = signed'({1'b0, loss});
  assign jd      = signed'({f_rd[WAVE_W-1], f_rd}) - signed'({b_rd[WAVE_W-1], b_rd});
  assign m_prod  = signed'(k_rd) * jd;
  assign e0_sum  = signed'({b_rd[WAVE_W-1], b_rd}) + signed'({exc_q[WAVE_W-1], exc_q});
  assign el_neg  = -signed'({f_rd[WAVE_W-1], f_rd});
  assign pr_sum  = signed'({f_rd[WAVE_W-1], f_rd}) + signed'({b_rd[WAVE_W-1], b_rd});
  assign e0_prod = e0_sum * loss_s;
  assign el_prod = el_neg * loss_s;
  assign tfl     = signed'({1'b0, tf_q[21:0]});
  assign tbl     = signed'({1'b0, tb_q[21:0]});
  assign tfh     = signed'(tf_q[TF_W-1:22]);
  assign tbh     = signed'(tb_q[TF_W-1:22]);
  assign pf_lo   = tfl * loss_s;
  assign pb_lo   = tbl * loss_s;
  assign pf_hi   = tfh * loss_s;
  assign pb_hi   = tbh * loss_s;
  assign f_new   = rnd_sat(accf, 32);
  assign b_new   = rnd_sat(accb, 32);
  assign sq_rd   = r_rd * r_rd;
  assign sq_nw   = rad_q * rad_q;
  assign rem_ge  = rem >= {2'b00, s_q};
  assign rem_sub = rem - {2'b00, s_q};
  assign q_round = (19'(quo) + 19'd1) >> 1;
  assign k_new   = zero_q ? '0 : (neg_q ? -q_round[COEF_W-1:0] : q_round[COEF_W-1:0]);

  // Status towards the controller.
  always_comb begin
    status.req_type = req_q;
    status.idx_ok   = idx_ok_q;
    status.idx_zero = (idx_q == '0);
    status.idx_last = (idx_q == LAST);
    status.j_last   = (j == AW'(SECTIONS - 2));
    status.clr_last = (clr_addr == LAST);
    status.div_last = (div_cnt == 5'd17);
    status.phase_hi = phase_hi;
  end

  // Memory addressing per operation. The junction loop writes both wave
  // stores at j while it reads the next junction's operands.
  always_comb begin
    fw_we = 1'b0; bw_we = 1'b0; rr_we = 1'b0; kr_we = 1'b0;
    fw_re = 1'b0; bw_re = 1'b0; rr_re = 1'b0; kr_re = 1'b0;
    fw_waddr = j; bw_waddr = j; rr_waddr = idx_q; kr_waddr = idx_q;
    fw_raddr = j; bw_raddr = j; rr_raddr = idx_q; kr_raddr = j;
    fw_wdata = '0; bw_wdata = '0; rr_wdata = '0; kr_wdata = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        fw_we = 1'b1; bw_we = 1'b1; rr_we = 1'b1; kr_we = 1'b1;
        fw_waddr = clr_addr; bw_waddr = clr_addr;
        rr_waddr = clr_addr; kr_waddr = clr_addr;
      end
      OP_END_RD: begin
        fw_re = 1'b1; fw_raddr = LAST;
        bw_re = 1'b1; bw_raddr = '0;
      end
      OP_END_RND: begin
        fw_re = 1'b1; fw_raddr = '0;
        bw_re = 1'b1; bw_raddr = AW'(1);
        kr_re = 1'b1; kr_raddr = '0;
      end
      OP_J_WR: begin
        fw_we = 1'b1; fw_wdata = fpend;
        bw_we = 1'b1; bw_wdata = b_new;
        if (!status.j_last) begin
          fw_re = 1'b1; fw_raddr = j + AW'(1);
          bw_re = 1'b1; bw_raddr = j + AW'(2);
          kr_re = 1'b1; kr_raddr = j + AW'(1);
        end
      end
      OP_LAST_WR: begin
        fw_we = 1'b1; fw_waddr = LAST; fw_wdata = fpend;
        bw_we = 1'b1; bw_waddr = LAST; bw_wdata = blast;
      end
      OP_PR_RD: begin
        fw_re = 1'b1; fw_raddr = idx_q;
        bw_re = 1'b1; bw_raddr = idx_q;
      end
      OP_RAD_WR: begin
        rr_we = 1'b1; rr_wdata = rad_q;
        rr_re = !status.idx_zero; rr_raddr = idx_q - AW'(1);
      end
      OP_K_RD: begin
        rr_re = 1'b1; rr_raddr = idx_q + AW'(1);
      end
      OP_K_WR: begin
        kr_we = 1'b1; kr_wdata = k_new;
        kr_waddr = phase_hi ? idx_q : idx_q - AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers: loss factor, clearing pointer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      loss          <= LOSS_UNITY;
      clr_addr      <= '0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_we) begin
        loss <= cfg_data;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      result_strobe <= (cmd.op == OP_LAST_WR) || (cmd.op == OP_PR_OUT);
    end
  end

  // Payload registers, loaded step by step as the controller directs.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_q    <= req_type;
        idx_q    <= AW'(section_index);
        idx_ok_q <= (32'(section_index) < 32'(SECTIONS));
        exc_q    <= excitation;
        rad_q    <= radius_value;
      end
      OP_END_MUL: begin
        lip_q <= signed'(f_rd);
        p0_q  <= e0_prod;
        pl_q  <= el_prod;
      end
      OP_END_RND: begin
        fpend <= rnd_sat(64'(p0_q), 16);
        blast <= rnd_sat(64'(pl_q), 16);
        j     <= '0;
      end
      OP_J_MK: begin
        tf_q <= (TF_W'(signed'(f_rd)) <<< 16) + TF_W'(m_prod);
        tb_q <= (TF_W'(signed'(b_rd)) <<< 16) + TF_W'(m_prod);
      end
      OP_J_LO: begin
        accf <= 64'(pf_lo);
        accb <= 64'(pb_lo);
      end
      OP_J_HI: begin
        accf <= accf + (64'(pf_hi) <<< 22);
        accb <= accb + (64'(pb_hi) <<< 22);
      end
      OP_J_WR: begin
        fpend <= f_new;
        j     <= j + AW'(1);
      end
      OP_LAST_WR: begin
        result_value <= lip_q;
        result_kind  <= KIND_LIP;
      end
      OP_PR_OUT: begin
        result_value <= rnd_sat(64'(pr_sum), 1);
        result_kind  <= KIND_PRESSURE;
      end
      OP_RAD_WR: begin
        phase_hi <= 1'b0;
      end
      OP_K_RD: begin
        phase_hi <= 1'b1;
      end
      OP_K_SQ: begin
        sq_a <= phase_hi ? sq_nw : sq_rd;
        sq_b <= phase_hi ? sq_rd : sq_nw;
      end
      OP_K_SUM: begin
        s_q     <= 33'(sq_a) + 33'(sq_b);
        zero_q  <= (sq_a == '0) && (sq_b == '0);
        neg_q   <= sq_a < sq_b;
        rem     <= (sq_a < sq_b) ? 35'(sq_b - sq_a) : 35'(sq_a - sq_b);
        quo     <= '0;
        div_cnt <= '0;
      end
      OP_K_DIV: begin
        quo     <= {quo[16:0], rem_ge};
        rem     <= (rem_ge ? rem_sub : rem) << 1;
        div_cnt <= div_cnt + 5'd1;
      end
      default: begin
      end
    endcase
  end

  klt_ram #(.WIDTH(WAVE_W), .DEPTH(SECTIONS)) u_fwd (
    .clk, .we(fw_we), .waddr(fw_waddr), .wdata(fw_wdata),
    .re(fw_re), .raddr(fw_raddr), .rdata(f_rd)
  );

  klt_ram #(.WIDTH(WAVE_W), .DEPTH(SECTIONS)) u_bwd (
    .clk, .we(bw_we), .waddr(bw_waddr), .wdata(bw_wdata),
    .re(bw_re), .raddr(bw_raddr), .rdata(b_rd)
  );

  klt_ram #(.WIDTH(RAD_W), .DEPTH(SECTIONS)) u_rad (
    .clk, .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
    .re(rr_re), .raddr(rr_raddr), .rdata(r_rd)
  );

  klt_ram #(.WIDTH(COEF_W), .DEPTH(SECTIONS)) u_coef (
    .clk, .we(kr_we), .waddr(kr_waddr), .wdata(kr_wdata),
    .re(kr_re), .raddr(kr_raddr), .rdata(k_rd)
  );

endmodule

### rtl/core/klt_ctrl.sv
// Controller state machine of the tract step: sequences the datapath.
// Uses klt_pkg for the state, operation and status types.
module klt_ctrl
  import klt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  klt_status_t status,
  output klt_cmd_t    cmd
);

  klt_state_t state, state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (status.req_type == REQ_SAMPLE) begin
          state_next = ST_END_RD;
        end else if (status.req_type == REQ_RADIUS && status.idx_ok) begin
          state_next = ST_RAD_WR;
        end else if (status.req_type == REQ_READ && status.idx_ok) begin
          state_next = ST_PR_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_END_RD:   state_next = ST_END_MUL;
      ST_END_MUL:  state_next = ST_END_RND;
      ST_END_RND:  state_next = ST_J_MK;
      ST_J_MK:     state_next = ST_J_LO;
      ST_J_LO:     state_next = ST_J_HI;
      ST_J_HI:     state_next = ST_J_WR;
      ST_J_WR:     state_next = status.j_last ? ST_LAST_WR : ST_J_MK;
      ST_LAST_WR:  state_next = ST_IDLE;
      ST_PR_RD:    state_next = ST_PR_OUT;
      ST_PR_OUT:   state_next = ST_IDLE;
      ST_RAD_WR: begin
        if (!status.idx_zero) begin
          state_next = ST_K_SQ;
        end else if (!status.idx_last) begin
          state_next = ST_K_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_K_RD:     state_next = ST_K_SQ;
      ST_K_SQ:     state_next = ST_K_SUM;
      ST_K_SUM:    state_next = ST_K_DIV;
      ST_K_DIV:    if (status.div_last) state_next = ST_K_WR;
      ST_K_WR: begin
        state_next = (!status.phase_hi && !status.idx_last) ? ST_K_RD : ST_IDLE;
      end
      default:     state_next = ST_CLEAR;
    endcase
  end

  // Outputs: one datapath operation per state.
  always_comb begin
    busy   = (state != ST_IDLE);
    cmd.op = OP_NONE;
    unique case (state)
      ST_CLEAR:    cmd.op = OP_CLEAR;
      ST_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
      ST_DISPATCH: cmd.op = OP_NONE;
      ST_END_RD:   cmd.op = OP_END_RD;
      ST_END_MUL:  cmd.op = OP_END_MUL;
      ST_END_RND:  cmd.op = OP_END_RND;
      ST_J_MK:     cmd.op = OP_J_MK;
      ST_J_LO:     cmd.op = OP_J_LO;
      ST_J_HI:     cmd.op = OP_J_HI;
      ST_J_WR:     cmd.op = OP_J_WR;
      ST_LAST_WR:  cmd.op = OP_LAST_WR;
      ST_PR_RD:    cmd.op = OP_PR_RD;
      ST_PR_OUT:   cmd.op = OP_PR_OUT;
      ST_RAD_WR:   cmd.op = OP_RAD_WR;
      ST_K_RD:     cmd.op = OP_K_RD;
      ST_K_SQ:     cmd.op = OP_K_SQ;
      ST_K_SUM:    cmd.op = OP_K_SUM;
      ST_K_DIV:    cmd.op = OP_K_DIV;
      ST_K_WR:     cmd.op = OP_K_WR;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/core/kelly_lochbaum_tract_step.sv
// Kelly-Lochbaum tract step. A sample step runs the end-section states and then passes each
// junction through J_MK, J_LO, J_HI and J_WR; the end-section write then shows its result.
// A pressure read shows its result after reading both wave stores; set radius stays busy while
// its 18-step coefficient divider runs once per neighbour. The receiver cannot stall, so a new
// request is taken in the cycle its predecessor's result is shown.
// Synchronous reset restores unity loss and then clears all stores, section by section.
module kelly_lochbaum_tract_step
  import klt_pkg::*;
#(
  parameter int SECTIONS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [IDX_W-1:0]         section_index,
  input  logic signed [WAVE_W-1:0] excitation,
  input  logic [RAD_W-1:0]         radius_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LOSS_W-1:0]        cfg_data,
  output logic                     result_strobe,
  output logic signed [WAVE_W-1:0] result_value,
  output logic                     result_kind
);

  klt_cmd_t    cmd;
  klt_status_t status;

  // The loss register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;

  klt_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .status, .cmd
  );

  klt_datapath #(.SECTIONS(SECTIONS)) u_dp (
    .clk, .rst, .cmd, .status,
    .req_type, .section_index, .excitation, .radius_value,
    .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .result_strobe, .result_value, .result_kind
  );

`ifndef SYNTHESIS
  // Every request gives at most one result, so strobes never sit back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for more than one cycle");

  // A result only follows the final write of a sample step or a pressure read.
  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(cmd.op == OP_LAST_WR || cmd.op == OP_PR_OUT))
    else $error("result strobe without a producing operation");

  // The last junction is followed by the end-section write.
  a_loop_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_J_WR && status.j_last) |=> (cmd.op == OP_LAST_WR))
    else $error("junction loop did not finish with the end-section write");

  // The clearing pass never runs while the block reports itself free.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CLEAR) |-> busy)
    else $error("clearing pass while not busy");
`endif

endmodule
